// ----- src/dcc_pkg.sv -----
// Package for the DAG cycle check unit: sizes, input command codes,
// controller states and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package dcc_pkg;

    localparam int MAX_NODES        = 32;
    localparam int NODE_W           = $clog2(MAX_NODES);
    localparam int COUNT_W          = 6;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(MAX_NODES);

    // Input item command codes
    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_EVAL     = 1'b1;

    typedef logic [MAX_NODES-1:0] t_node_mask;

    typedef enum logic {
        S_IDLE,
        S_PEEL
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic add_edge;     // store the edge of the accepted item
        logic eval_start;   // load the alive mask with the in-use nodes
        logic peel_step;    // drop every alive node with an empty column
        logic finish;       // capture the result, clear the matrix
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic progress;     // at least one node can be removed this cycle
    } t_dp_status;

endpackage

// ----- src/dcc_datapath.sv -----
// Datapath of the DAG cycle check unit: adjacency bit matrix, alive mask,
// node count register and result bit. Driven by dcc_ctrl; uses dcc_pkg.
`timescale 1ns / 1ps

module dcc_datapath
    import dcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [COUNT_W-1:0]  i_cfg_wr_data,
    input  logic [NODE_W-1:0]   i_source_node,
    input  logic [NODE_W-1:0]   i_target_node,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    output logic                o_is_acyclic
);

    t_node_mask          r_matrix [MAX_NODES];
    t_node_mask          r_alive;
    logic [COUNT_W-1:0]  r_node_count;
    logic                r_is_acyclic;

    logic [COUNT_W-1:0]  w_used_count;
    t_node_mask          w_used_mask;
    t_node_mask          w_col_busy;
    t_node_mask          w_remove;
    logic                w_any_edge;

    // Clamp node_count into 1..MAX_NODES
    always_comb begin
        if (r_node_count == '0) begin
            w_used_count = COUNT_W'(1);
        end else if (r_node_count > COUNT_W'(MAX_NODES)) begin
            w_used_count = COUNT_W'(MAX_NODES);
        end else begin
            w_used_count = r_node_count;
        end
    end

    always_comb begin
        for (int r = 0; r < MAX_NODES; r++) begin
            w_used_mask[r] = (COUNT_W'(r) < w_used_count);
        end
    end

    // A removed node's row counts as zeroed: only alive rows feed the columns.
    always_comb begin
        w_col_busy = '0;
        w_any_edge = 1'b0;
        for (int r = 0; r < MAX_NODES; r++) begin
            w_col_busy = w_col_busy | (r_matrix[r] & {MAX_NODES{r_alive[r]}});
            w_any_edge = w_any_edge | (|r_matrix[r]);
        end
    end

    assign w_remove          = r_alive & ~w_col_busy;
    assign o_status.progress = |w_remove;
    assign o_is_acyclic      = r_is_acyclic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_node_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_NODES; r++) begin
                r_matrix[r] <= '0;
            end
            r_alive <= '1;
        end else begin
            if (i_cmd.add_edge) begin
                r_matrix[i_source_node][i_target_node] <= 1'b1;
            end
            if (i_cmd.eval_start) begin
                r_alive <= w_used_mask;
            end else if (i_cmd.peel_step) begin
                r_alive <= r_alive & ~w_remove;
            end else if (i_cmd.finish) begin
                r_alive <= '1;
            end
            if (i_cmd.finish) begin
                for (int r = 0; r < MAX_NODES; r++) begin
                    r_matrix[r] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_is_acyclic <= (r_alive == '0);
        end
    end

    a_peel_only_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.peel_step |=> ((r_alive & ~$past(r_alive)) == '0))
        else $error("peel step revived a node");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (!w_any_edge && (r_alive == '1)))
        else $error("matrix not cleared after evaluation");

    a_start_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval_start |=> ((r_alive & ~w_used_mask) == '0) && (r_alive != '0))
        else $error("alive mask holds nodes outside node_count");

endmodule

// ----- src/dcc_ctrl.sv -----
// Controller of the DAG cycle check unit: input and output handshakes and
// the idle/peel state machine that sequences dcc_datapath. Uses dcc_pkg.
`timescale 1ns / 1ps

module dcc_ctrl
    import dcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_dp_cmd     o_cmd,
    input  t_dp_status  i_status
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_in_accept;
    logic   w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    if (i_command == CMD_EVAL) begin
                        o_cmd.eval_start = 1'b1;
                        n_state          = S_PEEL;
                    end else begin
                        o_cmd.add_edge   = 1'b1;
                    end
                end
            end
            S_PEEL: begin
                if (i_status.progress) begin
                    o_cmd.peel_step = 1'b1;
                end else if (w_out_free) begin
                    // nothing left to remove: hand out the result
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_result_after_peel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_PEEL))
        else $error("result raised outside evaluation");

    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> ((r_state == S_IDLE) && r_out_valid))
        else $error("evaluation end did not return to idle with a result");

endmodule

// ----- src/dag_cycle_check_unit.sv -----
// Top level of the DAG cycle check unit: joins dcc_ctrl and dcc_datapath.
// Uses dcc_pkg.
`timescale 1ns / 1ps

// Builds a directed graph one edge per item into a 32 by 32 adjacency bit
// matrix and, on an evaluate item, reports whether it is acyclic. An add-edge
// item gives no result. An evaluate item stalls the input through its removal
// rounds: each round ORs every in-use alive row of the matrix into a
// column mask and drops all alive nodes with an empty column at once. The
// final step loads the output register, clears the whole matrix and reopens
// the input; it waits there while an earlier result is still stalled. Self
// loops count as cycles. Write node_count only while the block is idle.

module dag_cycle_check_unit
    import dcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [COUNT_W-1:0]  i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_command,
    input  logic [NODE_W-1:0]   i_source_node,
    input  logic [NODE_W-1:0]   i_target_node,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_is_acyclic
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    dcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    dcc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_source_node (i_source_node),
        .i_target_node (i_target_node),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_is_acyclic  (o_is_acyclic)
    );

endmodule

// ----- tb/dag_cycle_check_checker.sv -----
// Checker for the DAG cycle check unit: watches the config port and both
// item channels, predicts each verdict and compares it. Uses dcc_pkg.
`timescale 1ns / 1ps

module dag_cycle_check_checker
    import dcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [COUNT_W-1:0]  i_cfg_wr_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_command,
    input  logic [NODE_W-1:0]   i_source_node,
    input  logic [NODE_W-1:0]   i_target_node,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_is_acyclic,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results_seen,
    output int                  o_acyclic_seen
);

    t_node_mask         adj_rows [MAX_NODES];
    logic [COUNT_W-1:0] node_count_q;
    bit                 verdict_q [$];
    int                 fail_cnt;
    int                 result_cnt;
    int                 acyclic_cnt;

    initial begin
        fail_cnt    = 0;
        result_cnt  = 0;
        acyclic_cnt = 0;
    end

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_cnt++;
    endtask

    // Peel every alive node whose in-use column is empty until nothing moves.
    function automatic bit graph_is_acyclic();
        int         n;
        t_node_mask alive;
        t_node_mask col_hits;
        bit         removed_any;
        n = (node_count_q == 0) ? 1 :
            (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
        alive = '0;
        for (int i = 0; i < n; i++) alive[i] = 1'b1;
        do begin
            removed_any = 1'b0;
            col_hits = '0;
            // rows of removed nodes count as zeroed
            for (int i = 0; i < n; i++)
                if (alive[i]) col_hits |= adj_rows[i];
            for (int j = 0; j < n; j++) begin
                if (alive[j] && !col_hits[j]) begin
                    alive[j] = 1'b0;
                    removed_any = 1'b1;
                end
            end
        end while (removed_any);
        return alive == '0;
    endfunction

    always @(posedge i_clk) begin
        bit exp_verdict;
        if (!i_rst_n) begin
            node_count_q = NODE_COUNT_RESET;
            for (int i = 0; i < MAX_NODES; i++) adj_rows[i] = '0;
            verdict_q.delete();
        end else begin
            if (i_cfg_wr_en) node_count_q = i_cfg_wr_data;

            // a result leaving now belongs to an earlier item: pop first
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("verdict %0b with none predicted",
                                              i_is_acyclic));
                end else begin
                    exp_verdict = verdict_q.pop_front();
                    if (i_is_acyclic !== exp_verdict)
                        report_mismatch($sformatf(
                            "graph %0d: is_acyclic %b, predicted %0b",
                            result_cnt, i_is_acyclic, exp_verdict));
                end
                result_cnt++;
                if (i_is_acyclic === 1'b1) acyclic_cnt++;
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_command == CMD_ADD_EDGE) begin
                    adj_rows[i_source_node][i_target_node] = 1'b1;
                end else begin
                    verdict_q.push_back(graph_is_acyclic());
                    for (int i = 0; i < MAX_NODES; i++) adj_rows[i] = '0;
                end
            end
        end
        o_fail_count   <= fail_cnt;
        o_pending      <= verdict_q.size();
        o_results_seen <= result_cnt;
        o_acyclic_seen <= acyclic_cnt;
    end

endmodule

// ----- tb/dag_cycle_check_unit_test.sv -----
// Top of the DAG cycle check unit testbench: clock, reset, edge and evaluate
// stimulus, output stalls and the verdict. Uses dcc_pkg and the checker.
`timescale 1ns / 1ps

module dag_cycle_check_unit_test;
    import dcc_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [COUNT_W-1:0] i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_command;
    logic [NODE_W-1:0]  i_source_node;
    logic [NODE_W-1:0]  i_target_node;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_is_acyclic;

    int fail_count;
    int pending;
    int results_seen;
    int acyclic_seen;

    int items_sent;
    int settings_used;
    int cur_nodes;
    bit tx_steady;
    bit rx_steady;
    bit rx_hold_req;

    int count_plan [12] = '{32, 2, 1, 7, 0, 16, 63, 31, 3, 40, 12, 5};

    dag_cycle_check_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_source_node (i_source_node),
        .i_target_node (i_target_node),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_is_acyclic  (o_is_acyclic)
    );

    dag_cycle_check_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_source_node  (i_source_node),
        .i_target_node  (i_target_node),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_is_acyclic   (o_is_acyclic),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_acyclic_seen (acyclic_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("dag_cycle_check_unit_test: FAIL");
        $finish;
    end

    // Output side: random stall runs, steady stretches, one long hold-off.
    initial begin
        int run;
        int r;
        bit stall_now;
        i_out_stall = 1'b0;
        run = 0;
        stall_now = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_now = 1'b1;
                run = 300;
            end else if (run == 0) begin
                r = $urandom_range(0, 99);
                if (rx_steady || r < 60) begin
                    stall_now = 1'b0;
                    run = $urandom_range(1, 6);
                end else if (r < 95) begin
                    stall_now = 1'b1;
                    run = $urandom_range(1, 3);
                end else begin
                    stall_now = 1'b1;
                    run = $urandom_range(10, 40);
                end
            end
            i_out_stall <= stall_now;
            run--;
        end
    end

    // Call right after a rising edge; returns right after the accepting edge.
    task automatic send_item(logic cmd, int src, int tgt);
        int  r;
        int  gap;
        bit  taken;
        r = $urandom_range(0, 99);
        gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        if (!tx_steady && gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_source_node <= NODE_W'(src);
        i_target_node <= NODE_W'(tgt);
        // stall is settled by the falling edge
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
    endtask

    task automatic wait_for_results(int settle);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Drain the block, then write node_count while it sits idle.
    task automatic set_node_count(int value);
        wait_for_results(40);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= COUNT_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_nodes = (value == 0) ? 1 : (value > MAX_NODES) ? MAX_NODES : value;
        settings_used++;
    endtask

    initial begin
        int order [MAX_NODES];
        int n;
        int kind;
        int a;
        int b;
        int tmp;
        int phase;
        int phase_end;
        int graphs_in_phase;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_command     = CMD_ADD_EDGE;
        i_source_node = '0;
        i_target_node = '0;
        items_sent    = 0;
        settings_used = 0;
        cur_nodes     = MAX_NODES;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        rx_hold_req   = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty graph, self loops at both ends, two-node cycle
        // across the extremes, repeated edge.
        send_item(CMD_EVAL, $urandom, $urandom);
        send_item(CMD_ADD_EDGE, 0, 0);
        send_item(CMD_EVAL, $urandom, $urandom);
        send_item(CMD_ADD_EDGE, 31, 31);
        send_item(CMD_EVAL, $urandom, $urandom);
        send_item(CMD_ADD_EDGE, 0, 31);
        send_item(CMD_ADD_EDGE, 31, 0);
        send_item(CMD_EVAL, $urandom, $urandom);
        send_item(CMD_ADD_EDGE, 3, 4);
        send_item(CMD_ADD_EDGE, 3, 4);
        send_item(CMD_ADD_EDGE, 4, 5);
        send_item(CMD_EVAL, $urandom, $urandom);

        // Edges touching nodes outside the in-use range have no effect.
        set_node_count(4);
        send_item(CMD_ADD_EDGE, 2, 9);
        send_item(CMD_ADD_EDGE, 9, 2);
        send_item(CMD_ADD_EDGE, 10, 10);
        send_item(CMD_EVAL, $urandom, $urandom);

        // Zero count acts as one node.
        set_node_count(0);
        send_item(CMD_ADD_EDGE, 0, 0);
        send_item(CMD_EVAL, $urandom, $urandom);
        send_item(CMD_ADD_EDGE, 1, 1);
        send_item(CMD_EVAL, $urandom, $urandom);

        // Oversized count saturates to all nodes.
        set_node_count(63);
        send_item(CMD_ADD_EDGE, 30, 31);
        send_item(CMD_ADD_EDGE, 31, 30);
        send_item(CMD_EVAL, $urandom, $urandom);

        phase = 0;
        while (items_sent < 1600) begin
            set_node_count((phase < 12) ? count_plan[phase] : $urandom_range(0, 63));
            tx_steady = (phase % 4 == 1);
            rx_steady = (phase % 4 == 2);
            // tiny graphs here, so evaluations pile up behind the hold-off
            if (phase == 1) rx_hold_req = 1'b1;
            n = cur_nodes;
            phase_end = items_sent + 130;
            graphs_in_phase = 0;
            while (items_sent < phase_end) begin
                if (graphs_in_phase == 3 && phase != 1) wait_for_results(1);
                for (int i = 0; i < MAX_NODES; i++) order[i] = i;
                for (int i = n - 1; i > 0; i--) begin
                    a = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[a];
                    order[a] = tmp;
                end
                kind = $urandom_range(0, 99);
                if (kind >= 88) begin
                    // noise: any node pair, in use or not
                    repeat ($urandom_range(0, 20))
                        send_item(CMD_ADD_EDGE, $urandom, $urandom);
                end else begin
                    // forward edges along the shuffled order never close a cycle
                    if (kind < 40 || kind >= 55) begin
                        repeat ($urandom_range(0, (2 * n < 40) ? 2 * n : 40)) begin
                            a = $urandom_range(0, n - 1);
                            b = $urandom_range(0, n - 1);
                            if (a != b) begin
                                if (a > b) begin
                                    tmp = a;
                                    a = b;
                                    b = tmp;
                                end
                                send_item(CMD_ADD_EDGE, order[a], order[b]);
                            end
                        end
                    end
                    if (kind >= 40 && kind < 55) begin
                        for (int i = 0; i < n - 1; i++)
                            send_item(CMD_ADD_EDGE, order[i], order[i + 1]);
                    end else if (kind >= 55 && kind < 80) begin
                        // path a..b closed by a back edge; a == b is a self loop
                        a = $urandom_range(0, n - 1);
                        b = $urandom_range(a, n - 1);
                        for (int i = a; i < b; i++)
                            send_item(CMD_ADD_EDGE, order[i], order[i + 1]);
                        send_item(CMD_ADD_EDGE, order[b], order[a]);
                    end else if (kind >= 80) begin
                        a = order[$urandom_range(0, n - 1)];
                        send_item(CMD_ADD_EDGE, a, a);
                    end
                end
                send_item(CMD_EVAL, $urandom, $urandom);
                graphs_in_phase++;
            end
            phase++;
        end

        wait_for_results(40);
        $display("run summary: %0d items, %0d graphs checked (%0d acyclic)",
                 items_sent, results_seen, acyclic_seen);
        $display("run summary: %0d node_count writes, %0d random phases",
                 settings_used, phase);
        if (fail_count == 0 && pending == 0) begin
            $display("dag_cycle_check_unit_test: PASS");
        end else begin
            $display("dag_cycle_check_unit_test: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/dcc_pkg.sv
src/dcc_datapath.sv
src/dcc_ctrl.sv
src/dag_cycle_check_unit.sv
tb/dag_cycle_check_checker.sv
tb/dag_cycle_check_unit_test.sv
